// ----- src/spk_pkg.sv -----
// ----------------------------------------------------------------------------
// Speck counter generator package
// Shared types, codes and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package spk_pkg;

	// Default number of cipher rounds (and stored round keys).
	localparam int DEF_ROUND_COUNT = 27;

	// Word and rotation geometry of one Speck64 round.
	localparam int WORD_W    = 32;
	localparam int BLOCK_W   = 64;
	localparam int ROT_RIGHT = 8;
	localparam int ROT_LEFT  = 3;

	// Operation codes carried in the input tuser field.
	localparam int OP_W = 2;
	typedef enum logic [OP_W-1:0] {
		OP_GENERATE = 2'd0,
		OP_EXPAND   = 2'd1,
		OP_LOAD     = 2'd2,
		OP_NONE     = 2'd3
	} spk_op_t;

	// Configuration register indexes.
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_0 = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_1 = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_2 = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_3 = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic gen_start;  // latch the counter into x/y and increment it
		logic exp_start;  // load the key words and clear the counter
		logic ctr_load;   // load the counter from the input transaction
		logic enc_step;   // one encryption round
		logic exp_step;   // one key schedule round
		logic out_load;   // move the ciphertext into the output register
	} spk_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_round; // the round index points at the final round
		logic out_busy;   // the output register holds a result not yet taken
	} spk_sts_t;

endpackage

// ----- src/spk_ctrl.sv -----
// ----------------------------------------------------------------------------
// Speck counter generator controller
// Sequences key expansion and counter encryption over the shared round unit.
// ----------------------------------------------------------------------------
module spk_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  spk_pkg::spk_op_t  in_op,
	input  spk_pkg::spk_sts_t sts,
	output spk_pkg::spk_cmd_t cmd
);
	import spk_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ENCRYPT,
		ST_EXPAND,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Command decode from the current state and the incoming transaction.
	always_comb begin
		cmd           = '0;
		cmd.gen_start = accept && (in_op == OP_GENERATE);
		cmd.exp_start = accept && (in_op == OP_EXPAND);
		cmd.ctr_load  = accept && (in_op == OP_LOAD);
		cmd.enc_step  = (state_q == ST_ENCRYPT);
		cmd.exp_step  = (state_q == ST_EXPAND);
		cmd.out_load  = (state_q == ST_FINISH) && !sts.out_busy;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.gen_start) begin
						state_q <= ST_ENCRYPT;
					end else if (cmd.exp_start) begin
						state_q <= ST_EXPAND;
					end
				end
				ST_ENCRYPT: begin
					if (sts.last_round) begin
						state_q <= ST_FINISH;
					end
				end
				ST_EXPAND: begin
					if (sts.last_round) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FINISH: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/spk_dp.sv -----
// ----------------------------------------------------------------------------
// Speck counter generator datapath
// Key registers, round key store, counter, shared round unit and output
// register.
// ----------------------------------------------------------------------------
module spk_dp #(
	parameter int ROUND_COUNT = spk_pkg::DEF_ROUND_COUNT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  spk_pkg::spk_cmd_t                cmd,
	output spk_pkg::spk_sts_t                sts,
	input  logic [spk_pkg::BLOCK_W-1:0]      counter_value,
	input  logic                             cfg_write,
	input  logic [spk_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [spk_pkg::WORD_W-1:0]       cfg_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [spk_pkg::BLOCK_W-1:0]      out_data
);
	import spk_pkg::*;

	localparam int RND_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

	logic [WORD_W-1:0]  key_q [4];
	logic [WORD_W-1:0]  rk_mem [ROUND_COUNT];
	logic [WORD_W-1:0]  lane_q [3];
	logic [WORD_W-1:0]  x_q;
	logic [WORD_W-1:0]  y_q;
	logic [BLOCK_W-1:0] ctr_q;
	logic [RND_W-1:0]   rnd_q;
	logic [BLOCK_W-1:0] out_q;
	logic               out_valid_q;

	logic [WORD_W-1:0]  rx;
	logic [WORD_W-1:0]  ry;
	logic [WORD_W-1:0]  rk;
	logic [WORD_W-1:0]  xn;
	logic [WORD_W-1:0]  yn;

	// Shared Speck round: x = (rotr(x,8) + y) ^ k; y = rotl(y,3) ^ x.
	// During key expansion lane zero plays x, the running key plays y and
	// the round index is the round key.
	always_comb begin
		rx = cmd.exp_step ? lane_q[0] : x_q;
		ry = y_q;
		rk = cmd.exp_step ? WORD_W'(rnd_q) : rk_mem[rnd_q];
		xn = ({rx[ROT_RIGHT-1:0], rx[WORD_W-1:ROT_RIGHT]} + ry) ^ rk;
		yn = {ry[WORD_W-ROT_LEFT-1:0], ry[WORD_W-1:WORD_W-ROT_LEFT]} ^ xn;
	end

	assign sts.last_round = (rnd_q == RND_W'(ROUND_COUNT - 1));
	assign sts.out_busy   = out_valid_q && !out_ready;

	// Key word registers, written through the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KEY_WORD_0: key_q[0] <= cfg_data;
				REG_KEY_WORD_1: key_q[1] <= cfg_data;
				REG_KEY_WORD_2: key_q[2] <= cfg_data;
				REG_KEY_WORD_3: key_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Block counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (cmd.gen_start) begin
			ctr_q <= ctr_q + BLOCK_W'(1);
		end else if (cmd.exp_start) begin
			ctr_q <= '0;
		end else if (cmd.ctr_load) begin
			ctr_q <= counter_value;
		end
	end

	// Round index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
		end else if (cmd.gen_start || cmd.exp_start) begin
			rnd_q <= '0;
		end else if (cmd.enc_step || cmd.exp_step) begin
			rnd_q <= rnd_q + RND_W'(1);
		end
	end

	// Working words: cipher state during encryption, key schedule lanes
	// during expansion. The lanes rotate so lane zero is always the next one.
	always_ff @(posedge clk) begin
		if (cmd.gen_start) begin
			x_q <= ctr_q[BLOCK_W-1:WORD_W];
			y_q <= ctr_q[WORD_W-1:0];
		end else if (cmd.exp_start) begin
			y_q       <= key_q[0];
			lane_q[0] <= key_q[1];
			lane_q[1] <= key_q[2];
			lane_q[2] <= key_q[3];
		end else if (cmd.enc_step) begin
			x_q <= xn;
			y_q <= yn;
		end else if (cmd.exp_step) begin
			y_q       <= yn;
			lane_q[0] <= lane_q[1];
			lane_q[1] <= lane_q[2];
			lane_q[2] <= xn;
		end
	end

	// Round key store, filled one key per expansion round.
	always_ff @(posedge clk) begin
		if (cmd.exp_step) begin
			rk_mem[rnd_q] <= y_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= {x_q, y_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- src/speck64_128_counter_prng.sv -----
// ----------------------------------------------------------------------------
// Speck64/128 counter-mode random generator
// Encrypts a 64-bit counter with Speck64/128 and returns the ciphertext.
// ----------------------------------------------------------------------------
// A generate transaction (op 0) puts its result in the output register once
// its rounds are done. The accepting edge itself latches the counter into
// the round unit and increments it. The rounds then run through the single
// shared round unit, and the finish state loads the output register. The
// input is ready again in the cycle after that load. The finish state waits
// while an earlier result still waits in the output register, so the input
// stays busy longer then. A key expansion (op 1) holds the input while its
// rounds run on the same round unit. A counter load (op 2) and the unused
// op 3 leave the controller in the idle state. The input accepts one
// transaction at a time and is ready again while a result still waits in
// the output register. Key words written through the configuration port take
// effect at the next key expansion. A generate before any expansion returns
// undefined data.
module speck64_128_counter_prng #(
	parameter int ROUND_COUNT = spk_pkg::DEF_ROUND_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [spk_pkg::BLOCK_W-1:0]   s_axis_tdata,  // [63:0] counter_value
	input  logic [spk_pkg::OP_W-1:0]      s_axis_tuser,  // [1:0] op
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [spk_pkg::BLOCK_W-1:0]   m_axis_tdata,  // [63:0] random_word
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [spk_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [spk_pkg::WORD_W-1:0]    cfg_data
);
	import spk_pkg::*;

	spk_cmd_t cmd;
	spk_sts_t sts;
	spk_op_t  in_op;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;
	assign in_op     = spk_op_t'(s_axis_tuser);

	// Operation sequencer.
	spk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (in_op),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Cipher datapath.
	spk_dp #(
		.ROUND_COUNT (ROUND_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.counter_value (s_axis_tdata),
		.cfg_write     (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_data      (m_axis_tdata)
	);

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Speck64/128 counter generator testbench
// Drives key writes and generate, expand and load transactions into the
// block. An in-bench cipher predictor computes every random word, and each
// word that comes out is compared in order with the predicted one. The run
// covers a directed table and four random phases with different idle patterns.
// ----------------------------------------------------------------------------
module testbench;
	import spk_pkg::*;

	localparam int ROUNDS        = DEF_ROUND_COUNT;
	// Wait well past the length of one generate when settling.
	localparam int SETTLE_CYCLES = 2 * ROUNDS + 8;
	localparam int PHASE_ITEMS   = 275;
	localparam int DIRECTED_ROWS = 25;

	// Published Speck64/128 vector: key, plaintext and ciphertext.
	localparam logic [WORD_W-1:0]  VEC_KEY_0  = 32'h03020100;
	localparam logic [WORD_W-1:0]  VEC_KEY_1  = 32'h0b0a0908;
	localparam logic [WORD_W-1:0]  VEC_KEY_2  = 32'h13121110;
	localparam logic [WORD_W-1:0]  VEC_KEY_3  = 32'h1b1a1918;
	localparam logic [BLOCK_W-1:0] VEC_PLAIN  = 64'h3b726574_7475432d;
	localparam logic [BLOCK_W-1:0] VEC_CIPHER = 64'h8c6fa548_454e028b;

	// One row of the directed table: either a register write or a transaction.
	typedef struct packed {
		logic                 is_cfg;
		spk_op_t              op;
		logic [REG_IDX_W-1:0] reg_idx;
		logic [BLOCK_W-1:0]   value;
		logic                 has_known;
		logic [BLOCK_W-1:0]   known;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [BLOCK_W-1:0]   s_axis_tdata;
	spk_op_t              s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [BLOCK_W-1:0]   m_axis_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	// Cipher predictor state.
	logic [WORD_W-1:0]  key_words [4];
	logic [WORD_W-1:0]  round_keys [ROUNDS];
	logic [BLOCK_W-1:0] counter_state;
	logic [BLOCK_W-1:0] expected_words [$];

	int fail_count         = 0;
	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;

	speck64_128_counter_prng #(
		.ROUND_COUNT(ROUNDS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// One Speck round on the packed pair {x, y}.
	function automatic logic [BLOCK_W-1:0] mix_pair(input logic [BLOCK_W-1:0] xy,
			input logic [WORD_W-1:0] k);
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		x = xy[BLOCK_W-1:WORD_W];
		y = xy[WORD_W-1:0];
		x = ({x[ROT_RIGHT-1:0], x[WORD_W-1:ROT_RIGHT]} + y) ^ k;
		y = {y[WORD_W-ROT_LEFT-1:0], y[WORD_W-1:WORD_W-ROT_LEFT]} ^ x;
		return {x, y};
	endfunction

	// Key schedule: the round key runs as y, the three lanes take turns as x.
	function automatic void expand_round_keys();
		logic [WORD_W-1:0]  a;
		logic [WORD_W-1:0]  lane [3];
		logic [BLOCK_W-1:0] xy;
		a = key_words[0];
		lane[0] = key_words[1];
		lane[1] = key_words[2];
		lane[2] = key_words[3];
		for (int i = 0; i < ROUNDS; i++) begin
			round_keys[i] = a;
			xy = mix_pair({lane[i % 3], a}, WORD_W'(i));
			lane[i % 3] = xy[BLOCK_W-1:WORD_W];
			a = xy[WORD_W-1:0];
		end
		counter_state = '0;
	endfunction

	function automatic logic [BLOCK_W-1:0] encrypt_counter_word();
		logic [BLOCK_W-1:0] xy;
		xy = counter_state;
		for (int i = 0; i < ROUNDS; i++)
			xy = mix_pair(xy, round_keys[i]);
		return xy;
	endfunction

	// Update the predictor for one accepted input transaction.
	function automatic void predict_item(input spk_op_t op, input logic [BLOCK_W-1:0] value,
			input logic has_known, input logic [BLOCK_W-1:0] known);
		logic [BLOCK_W-1:0] word;
		case (op)
			OP_GENERATE: begin
				word = encrypt_counter_word();
				counter_state = counter_state + BLOCK_W'(1);
				expected_words.push_back(has_known ? known : word);
			end
			OP_EXPAND: expand_round_keys();
			OP_LOAD:   counter_state = value;
			default:   ;
		endcase
	endfunction

	// Present one transaction from a falling edge; returns on the falling edge
	// after acceptance so the next one can follow back to back.
	task automatic send_item(input spk_op_t op, input logic [BLOCK_W-1:0] value,
			input logic has_known, input logic [BLOCK_W-1:0] known);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_axis_tvalid = 1'b0;
			s_axis_tdata  = {$urandom, $urandom};
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = value;
		s_axis_tuser  = op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_item(op, value, has_known, known);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		key_words[idx] = data;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Drain all results, then let a possible key expansion finish too.
	task automatic wait_idle();
		s_axis_tvalid = 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic stim_row_t item_row(input spk_op_t op, input logic [BLOCK_W-1:0] value);
		return {1'b0, op, REG_KEY_WORD_0, value, 1'b0, {BLOCK_W{1'b0}}};
	endfunction

	// Directed table. Rows marked with a known word check the published vector;
	// the key word write in the middle must not reach the round keys until
	// the next expansion.
	function automatic stim_row_t directed_row(input int n);
		case (n)
			0:  return item_row(OP_EXPAND, 64'hffff_ffff_ffff_ffff);
			1:  return item_row(OP_LOAD, VEC_PLAIN);
			2:  return {1'b0, OP_GENERATE, REG_KEY_WORD_0, 64'h0, 1'b1, VEC_CIPHER};
			3:  return item_row(OP_GENERATE, 64'h0);
			4:  return item_row(OP_NONE, 64'hffff_ffff_ffff_ffff);
			5:  return item_row(OP_GENERATE, 64'h5555_5555_5555_5555);
			6:  return item_row(OP_LOAD, 64'hffff_ffff_ffff_ffff);
			7:  return item_row(OP_GENERATE, 64'h0);
			8:  return item_row(OP_GENERATE, 64'h0);
			9:  return item_row(OP_LOAD, 64'h5555_5555_5555_5555);
			10: return item_row(OP_GENERATE, 64'h0);
			11: return item_row(OP_LOAD, 64'haaaa_aaaa_aaaa_aaaa);
			12: return item_row(OP_GENERATE, 64'h0);
			13: return {1'b1, OP_NONE, REG_KEY_WORD_0, 64'hffff_ffff, 1'b0, 64'h0};
			14: return item_row(OP_GENERATE, 64'h0);
			15: return item_row(OP_LOAD, VEC_PLAIN);
			16: return {1'b0, OP_GENERATE, REG_KEY_WORD_0, 64'h0, 1'b1, VEC_CIPHER};
			17: return item_row(OP_EXPAND, 64'h0);
			18: return item_row(OP_GENERATE, 64'h0);
			19: return item_row(OP_LOAD, 64'h0);
			20: return item_row(OP_GENERATE, 64'h0);
			21: return {1'b1, OP_NONE, REG_KEY_WORD_0, {32'h0, VEC_KEY_0}, 1'b0, 64'h0};
			22: return item_row(OP_EXPAND, 64'h0);
			23: return item_row(OP_LOAD, VEC_PLAIN);
			default: return {1'b0, OP_GENERATE, REG_KEY_WORD_0, 64'h0, 1'b1, VEC_CIPHER};
		endcase
	endfunction

	// Output side: random stalls, changed on the falling edge.
	always @(negedge clk)
		m_axis_tready = ($urandom_range(0, 99) >= receiver_stall_pct);

	// Compare every output transaction with the oldest predicted word.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected random_word, expected none, got %h",
					$realtime, m_axis_tdata);
				fail_count++;
			end else begin
				if (m_axis_tdata !== expected_words[0]) begin
					$display("%0t: random_word mismatch, expected %h, got %h",
						$realtime, expected_words[0], m_axis_tdata);
					fail_count++;
				end
				void'(expected_words.pop_front());
			end
		end
	end

	initial begin
		stim_row_t          row;
		int                 issued;
		int                 pick;
		spk_op_t            op;
		logic [BLOCK_W-1:0] value;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_NONE;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_KEY_WORD_0;
		cfg_data      = '0;
		counter_state = '0;
		for (int i = 0; i < 4; i++)
			key_words[i] = '0;
		for (int i = 0; i < ROUNDS; i++)
			round_keys[i] = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, keyed with the published vector.
		write_register(REG_KEY_WORD_0, VEC_KEY_0);
		write_register(REG_KEY_WORD_1, VEC_KEY_1);
		write_register(REG_KEY_WORD_2, VEC_KEY_2);
		write_register(REG_KEY_WORD_3, VEC_KEY_3);
		for (int n = 0; n < DIRECTED_ROWS; n++) begin
			row = directed_row(n);
			if (row.is_cfg) begin
				wait_idle();
				write_register(row.reg_idx, row.value[WORD_W-1:0]);
			end else begin
				send_item(row.op, row.value, row.has_known, row.known);
			end
		end

		// Random phases: a new key each time, then a mixed transaction stream.
		for (int phase = 0; phase < 4; phase++) begin
			wait_idle();
			case (phase)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 75; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 75; end
				default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
			endcase
			write_register(REG_KEY_WORD_0, phase == 0 ? 32'h0 : phase == 1 ? 32'hffff_ffff : $urandom);
			write_register(REG_KEY_WORD_1, phase == 0 ? 32'h0 : phase == 1 ? 32'hffff_ffff : $urandom);
			write_register(REG_KEY_WORD_2, phase == 0 ? 32'h0 : phase == 1 ? 32'hffff_ffff : $urandom);
			write_register(REG_KEY_WORD_3, phase == 0 ? 32'h0 : phase == 1 ? 32'hffff_ffff : $urandom);
			send_item(OP_EXPAND, {$urandom, $urandom}, 1'b0, '0);
			issued = 0;
			while (issued < PHASE_ITEMS) begin
				pick  = $urandom_range(0, 99);
				value = {$urandom, $urandom};
				if (pick < 70)
					op = OP_GENERATE;
				else if (pick < 85)
					op = OP_LOAD;
				else if (pick < 93)
					op = OP_EXPAND;
				else
					op = OP_NONE;
				// Loads now and then land right at the wrap point or the extremes.
				if (op == OP_LOAD && $urandom_range(0, 9) == 0) begin
					case ($urandom_range(0, 2))
						0:       value = 64'hffff_ffff_ffff_fffe;
						1:       value = 64'hffff_ffff_ffff_ffff;
						default: value = 64'h0;
					endcase
				end
				send_item(op, value, 1'b0, '0);
				issued++;
			end
		end

		wait_idle();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
